@@ hw/rtl/lqrsl_pkg.sv @@
package lqrsl_pkg;

  localparam int unsigned GainEntries = 32;
  localparam int unsigned GainIdxW    = $clog2(GainEntries);
  localparam int unsigned CordicSteps = 17;
  localparam int unsigned DivSteps    = 36;

  localparam logic signed [16:0] SpeedFloor  = 17'sd26;
  localparam logic signed [20:0] TwoPiQ16    = 21'sd411775;
  localparam logic signed [20:0] UsPerSecond = 21'sd1000000;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_CONTROL = 2'd1,
    FUNC_HOLD    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_WHEELBASE   = 3'd0,
    REG_STEER_LIMIT = 3'd1,
    REG_GRID_MIN    = 3'd2,
    REG_GRID_MAX    = 3'd3,
    REG_GRID_INV    = 3'd4,
    REG_GAIN_COUNT  = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_POS, S_RD0, S_RD1, S_GRAB, S_INT, S_WB, S_CORDIC,
    S_FF, S_YAW, S_M1, S_M2, S_M3, S_SAT, S_RMUL, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         entry_index;
    logic signed [31:0] lateral_gain_in;
    logic signed [31:0] heading_gain_in;
    logic signed [31:0] actuator_gain_in;
    logic signed [15:0] lateral_error;
    logic [15:0]        vehicle_yaw;
    logic [15:0]        reference_yaw;
    logic signed [15:0] path_curvature;
    logic signed [15:0] speed;
    logic signed [15:0] measured_steer;
    logic [15:0]        step_period;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] steer_command;
    logic signed [31:0] steer_rate;
  } out_word_t;

  // CORDIC angle table, 2^-16 rad
  function automatic logic signed [19:0] atan_lut(input logic [4:0] i);
    logic signed [19:0] r;
    unique case (i)
      5'd0:    r = 20'sd51472;
      5'd1:    r = 20'sd30386;
      5'd2:    r = 20'sd16055;
      5'd3:    r = 20'sd8150;
      5'd4:    r = 20'sd4091;
      5'd5:    r = 20'sd2047;
      5'd6:    r = 20'sd1024;
      5'd7:    r = 20'sd512;
      5'd8:    r = 20'sd256;
      5'd9:    r = 20'sd128;
      5'd10:   r = 20'sd64;
      5'd11:   r = 20'sd32;
      5'd12:   r = 20'sd16;
      5'd13:   r = 20'sd8;
      5'd14:   r = 20'sd4;
      5'd15:   r = 20'sd2;
      5'd16:   r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/lqr_lateral_steer_law_core.sv @@
// Load word: written in the accept cycle, no result; block ready next cycle.
// Hold word: result written from S_OUT into the output register once it is free.
// Control word: result computed by 17 CORDIC steps and, when step_period is nonzero,
// a 36-step restoring divider around one 33x21 multiplier.
// One word at a time; the next is taken once the result is in the output register.
// Reset (async, active low) restores register defaults and clears the previous
// steer; gain table contents stay undefined until loaded.
module lqr_lateral_steer_law_core
  import lqrsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  // configuration
  logic [15:0] wheelbase_q, grid_min_q, grid_max_q, grid_inv_q;
  logic [14:0] steer_limit_q;
  logic [5:0]  gain_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q   <= 16'd2765;
      steer_limit_q <= 15'd9830;
      grid_min_q    <= 16'd256;
      grid_max_q    <= 16'd7680;
      grid_inv_q    <= 16'd256;
      gain_count_q  <= 6'd1;
    end else if (cfg_we_i) begin
      priority case (cfg_index_i)
        REG_WHEELBASE:   wheelbase_q   <= cfg_data_i;
        REG_STEER_LIMIT: steer_limit_q <= cfg_data_i[14:0];
        REG_GRID_MIN:    grid_min_q    <= cfg_data_i;
        REG_GRID_MAX:    grid_max_q    <= cfg_data_i;
        REG_GRID_INV:    grid_inv_q    <= cfg_data_i;
        REG_GAIN_COUNT:  gain_count_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [5:0] cnt_q;
  in_word_t in_q;
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // gain memory: {lateral, heading, actuator}
  logic [95:0] gain_mem [GainEntries];
  logic [95:0] rd_q;
  logic [GainIdxW-1:0] rd_addr;
  logic [GainIdxW-1:0] i0_q, i1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.func == FUNC_LOAD) begin
      gain_mem[in_data_i.entry_index[GainIdxW-1:0]] <=
        {in_data_i.lateral_gain_in, in_data_i.heading_gain_in, in_data_i.actuator_gain_in};
    end
    rd_q <= gain_mem[rd_addr];
  end

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [15:0] t_q;
  logic [95:0] g0_q, g1_q;
  logic signed [31:0] k_q [3];
  logic signed [36:0] cx_q, cy_q;
  logic signed [19:0] z_q;
  logic signed [17:0] ff_q;
  logic signed [18:0] yaw_q;
  logic signed [55:0] acc_q;
  logic signed [15:0] steer_q, prev_q;
  logic [35:0] num_q;
  logic [15:0] rem_q;
  logic neg_q, rate_zero_q;
  out_word_t out_q;
  logic out_valid_q;

  // speed to grid distance
  logic signed [16:0] v0, v1, v2;
  logic signed [17:0] grid_dist;
  always_comb begin
    v0 = 17'(in_q.speed);
    v1 = (v0 < SpeedFloor) ? SpeedFloor : v0;
    if (v1 < $signed({1'b0, grid_min_q})) v1 = $signed({1'b0, grid_min_q});
    v2 = (v1 > $signed({1'b0, grid_max_q})) ? $signed({1'b0, grid_max_q}) : v1;
    grid_dist = 18'(v2) - $signed({2'b0, grid_min_q});
    if (grid_dist < 0) grid_dist = '0;
  end

  // entries in use, minus one
  logic [GainIdxW-1:0] last_idx;
  always_comb begin
    if (gain_count_q == '0) last_idx = '0;
    else if (gain_count_q > 6'(GainEntries)) last_idx = GainIdxW'(GainEntries - 1);
    else last_idx = GainIdxW'(gain_count_q - 6'd1);
  end

  logic [15:0] ip;
  logic [GainIdxW-1:0] i0_c, i1_c;
  assign ip   = mul_p[31:16];
  assign i0_c = (ip > 16'(last_idx)) ? last_idx : ip[GainIdxW-1:0];
  assign i1_c = (i0_c >= last_idx) ? last_idx : i0_c + GainIdxW'(1);

  logic [1:0] lane;
  logic signed [31:0] g0_lane, g1_lane;
  assign lane    = cnt_q[1:0];
  assign g0_lane = (lane == 2'd0) ? g0_q[95:64] : (lane == 2'd1) ? g0_q[63:32] : g0_q[31:0];
  assign g1_lane = (lane == 2'd0) ? g1_q[95:64] : (lane == 2'd1) ? g1_q[63:32] : g1_q[31:0];

  logic signed [15:0] e_yaw;
  logic signed [17:0] meas_ff;
  logic signed [16:0] steer_diff;
  assign e_yaw      = $signed(in_q.vehicle_yaw - in_q.reference_yaw);
  assign meas_ff    = 18'(in_q.measured_steer) - ff_q;
  assign steer_diff = 17'(steer_q) - 17'(prev_q);

  // outputs of the sequencer: operand select, stall
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = i0_q;
    unique case (state_q)
      S_POS: begin
        mul_a = 33'(grid_dist);
        mul_b = $signed({5'b0, grid_inv_q});
      end
      S_RD1:  rd_addr = i1_q;
      S_INT: begin
        mul_a = 33'(g1_lane) - 33'(g0_lane);
        mul_b = $signed({5'b0, t_q});
      end
      S_WB: begin
        mul_a = $signed({17'b0, wheelbase_q});
        mul_b = 21'(in_q.path_curvature);
      end
      S_YAW: begin
        mul_a = 33'(e_yaw);
        mul_b = TwoPiQ16;
      end
      S_M1: begin
        mul_a = 33'(k_q[0]);
        mul_b = 21'(in_q.lateral_error);
      end
      S_M2: begin
        mul_a = 33'(k_q[1]);
        mul_b = 21'(yaw_q);
      end
      S_M3: begin
        mul_a = 33'(k_q[2]);
        mul_b = 21'(meas_ff);
      end
      S_RMUL: begin
        mul_a = 33'(steer_diff);
        mul_b = UsPerSecond;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.func == FUNC_CONTROL) state_d = S_POS;
        else if (in_acc && in_data_i.func == FUNC_HOLD) state_d = S_OUT;
      end
      S_POS:    state_d = S_RD0;
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_GRAB;
      S_GRAB:   state_d = S_INT;
      S_INT:    if (cnt_q == 6'd2) state_d = S_WB;
      S_WB:     state_d = S_CORDIC;
      S_CORDIC: if (cnt_q == 6'(CordicSteps - 1)) state_d = S_FF;
      S_FF:     state_d = S_YAW;
      S_YAW:    state_d = S_M1;
      S_M1:     state_d = S_M2;
      S_M2:     state_d = S_M3;
      S_M3:     state_d = S_SAT;
      S_SAT:    state_d = S_RMUL;
      S_RMUL:   state_d = (in_q.step_period == '0) ? S_OUT : S_DIV;
      S_DIV:    if (cnt_q == 6'(DivSteps - 1)) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // CORDIC step
  logic [4:0] sh;
  logic signed [36:0] dx, dy;
  assign sh = cnt_q[4:0];
  assign dx = cy_q >>> sh;
  assign dy = cx_q >>> sh;

  // steer sum and clamp
  logic signed [37:0] steer_raw;
  logic signed [37:0] lim;
  logic signed [15:0] steer_c;
  assign steer_raw = 38'(acc_q >>> 18);
  assign lim       = $signed({23'b0, steer_limit_q});
  always_comb begin
    if (steer_raw > lim) steer_c = 16'(lim);
    else if (steer_raw < -lim) steer_c = 16'(-lim);
    else steer_c = 16'(steer_raw);
  end

  // divider step
  logic [16:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, num_q[35]};
  assign q_bit  = rem_sh >= {1'b0, in_q.step_period};

  logic signed [53:0] abs_p;
  assign abs_p = mul_p[53] ? -mul_p : mul_p;

  logic signed [31:0] rate_c;
  always_comb begin
    if (rate_zero_q) rate_c = '0;
    else if (neg_q) rate_c = (num_q > 36'h080000000) ? 32'sh80000000 : -$signed(num_q[31:0]);
    else rate_c = (num_q > 36'h07fffffff) ? 32'sh7fffffff : $signed(num_q[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   cnt_q <= '0;
        S_INT:    cnt_q <= (cnt_q == 6'd2) ? '0 : cnt_q + 6'd1;
        S_CORDIC: cnt_q <= (cnt_q == 6'(CordicSteps - 1)) ? '0 : cnt_q + 6'd1;
        S_DIV:    cnt_q <= cnt_q + 6'd1;
        S_OUT: begin
          cnt_q <= '0;
          if (out_free && in_q.func == FUNC_CONTROL) prev_q <= steer_q;
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    unique case (state_q)
      S_IDLE: begin
        steer_q     <= prev_q;
        rate_zero_q <= 1'b1;
      end
      S_POS: begin
        t_q  <= mul_p[15:0];
        i0_q <= i0_c;
        i1_q <= i1_c;
      end
      S_RD1:  g0_q <= rd_q;
      S_GRAB: g1_q <= rd_q;
      S_INT:  k_q[lane] <= g0_lane + 32'(mul_p >>> 16);
      S_WB: begin
        cx_q <= 37'sd1 <<< 26;
        cy_q <= 37'(mul_p);
        z_q  <= '0;
      end
      S_CORDIC: begin
        if (!cy_q[36]) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + atan_lut(sh);
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - atan_lut(sh);
        end
      end
      S_FF:  ff_q <= 18'((z_q + 20'sd2) >>> 2);
      S_YAW: begin
        yaw_q <= 19'(mul_p >>> 16);
        acc_q <= 56'(ff_q) <<< 18;
      end
      S_M1:  acc_q <= acc_q - (56'(mul_p) <<< 6);
      S_M2:  acc_q <= acc_q - 56'(mul_p);
      S_M3:  acc_q <= acc_q - (56'(mul_p) <<< 2);
      S_SAT: steer_q <= steer_c;
      S_RMUL: begin
        rate_zero_q <= (in_q.step_period == '0);
        neg_q       <= mul_p[53];
        num_q       <= 36'(abs_p);
        rem_q       <= '0;
      end
      S_DIV: begin
        rem_q <= q_bit ? 16'(rem_sh - {1'b0, in_q.step_period}) : rem_sh[15:0];
        num_q <= {num_q[34:0], q_bit};
      end
      S_OUT: begin
        if (out_free) begin
          out_q.steer_command <= steer_q;
          out_q.steer_rate    <= rate_c;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");
  a_ctrl_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.func == FUNC_CONTROL |=> state_q == S_POS)
    else $error("control word did not start the sequence");
  a_cordic_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORDIC |-> cnt_q < 6'(CordicSteps))
    else $error("CORDIC step count overrun");
  a_prev_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_OUT |=> $stable(prev_q))
    else $error("previous steer changed outside result write");

endmodule
